@@ design/bcslr_pkg.sv @@
// Shared constants, payload structs and codes for the bytecode store with line runs.
`default_nettype none
package bcslr_pkg;

   localparam int CODE_DEPTH = 4096;
   localparam int LINE_BITS  = 16;
   localparam int ADDR_BITS  = $clog2(CODE_DEPTH);
   localparam int COUNT_BITS = ADDR_BITS + 1;
   localparam int SUM_BITS   = COUNT_BITS + 1;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_EMPTY  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  code_byte;
      logic [15:0] source_line;
      logic [11:0] instr_index;
   } req_type;

   typedef struct packed {
      logic [15:0] found_line;
      logic [11:0] write_position;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [LINE_BITS-1:0]  line;
      logic [COUNT_BITS-1:0] length;
   } run_entry_type;

endpackage
`default_nettype wire

@@ design/bcslr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bcslr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ design/bytecode_store_with_line_runs.sv @@
// Top level: bytecode store with a run-length table of source lines.
// Append, clear and empty words, and queries out of range or with no runs recorded, are taken
// back to back; the result strobes on the next cycle and the receiver cannot hold it off.
// Any other query walks the run memory one entry per cycle, busy meanwhile, until a run
// reaches the index or every recorded run has been visited.
// Synchronous reset closes the run and zeroes the byte, run and length counters; memories keep their contents.
`default_nettype none
module bytecode_store_with_line_runs
   import bcslr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [COUNT_BITS-1:0] run_count_ff, run_count_in;
   logic [ADDR_BITS-1:0]  last_slot_ff, last_slot_in;
   logic [LINE_BITS-1:0]  cur_line_ff, cur_line_in;
   logic                  run_open_ff, run_open_in;
   logic [COUNT_BITS-1:0] cur_len_ff, cur_len_in;

   logic [COUNT_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic                  pend_ff, pend_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [ADDR_BITS-1:0]  qidx_ff, qidx_in;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic                 code_we;
   logic [ADDR_BITS-1:0] code_waddr;
   logic                 run_we;
   logic [ADDR_BITS-1:0] run_waddr;
   run_entry_type        run_wdata;
   run_entry_type        run_rdata;

   logic                 accept;
   logic                 query_go;
   logic                 walk_issue;
   logic [SUM_BITS-1:0]  sum_next;
   logic                 walk_hit;
   logic                 walk_done;
   logic [LINE_BITS-1:0] req_line;

   assign busy       = (state_ff == ST_WALK);
   assign accept     = start && !busy;
   assign req_line   = req_item.source_line[LINE_BITS-1:0];
   assign query_go   = accept && (req_item.mode == MODE_QUERY)
                       && ({1'b0, req_item.instr_index} < byte_count_ff)
                       && (run_count_ff != '0);
   assign walk_issue = rd_idx_ff < run_count_ff;
   assign sum_next   = sum_ff + SUM_BITS'(run_rdata.length);
   assign walk_hit   = pend_ff && (sum_next > SUM_BITS'(qidx_ff));
   assign walk_done  = walk_hit || (!pend_ff && !walk_issue);

   bcslr_ram #(
      .WIDTH(8),
      .DEPTH(CODE_DEPTH)
   ) u_code_ram (
      .clock(clock),
      .we   (code_we),
      .waddr(code_waddr),
      .wdata(req_item.code_byte),
      .raddr('0),
      .rdata()
   );

   bcslr_ram #(
      .WIDTH($bits(run_entry_type)),
      .DEPTH(CODE_DEPTH)
   ) u_run_ram (
      .clock(clock),
      .we   (run_we),
      .waddr(run_waddr),
      .wdata(run_wdata),
      .raddr(rd_idx_ff[ADDR_BITS-1:0]),
      .rdata(run_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      byte_count_in = byte_count_ff;
      run_count_in  = run_count_ff;
      last_slot_in  = last_slot_ff;
      cur_line_in   = cur_line_ff;
      run_open_in   = run_open_ff;
      cur_len_in    = cur_len_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = 1'b0;
      sum_in        = sum_ff;
      qidx_in       = qidx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      code_we       = 1'b0;
      code_waddr    = byte_count_ff[ADDR_BITS-1:0];
      run_we        = 1'b0;
      run_waddr     = last_slot_ff;
      run_wdata     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode_type'(req_item.mode))
                  MODE_APPEND: begin
                     rsp_strobe_in = 1'b1;
                     if (byte_count_ff == COUNT_BITS'(CODE_DEPTH)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        if (!run_open_ff || req_line != cur_line_ff) begin
                           // open a new run if the run table has room
                           if (run_count_ff < COUNT_BITS'(CODE_DEPTH)) begin
                              run_we           = 1'b1;
                              run_waddr        = run_count_ff[ADDR_BITS-1:0];
                              run_wdata.line   = req_line;
                              run_wdata.length = COUNT_BITS'(1);
                              cur_line_in      = req_line;
                              cur_len_in       = COUNT_BITS'(1);
                              last_slot_in     = run_count_ff[ADDR_BITS-1:0];
                              run_count_in     = run_count_ff + 1'b1;
                              run_open_in      = 1'b1;
                           end
                        end else begin
                           // grow the open run
                           run_we           = 1'b1;
                           run_wdata.line   = cur_line_ff;
                           run_wdata.length = cur_len_ff + 1'b1;
                           cur_len_in       = cur_len_ff + 1'b1;
                        end
                        code_we               = 1'b1;
                        rsp_in.write_position = byte_count_ff[ADDR_BITS-1:0];
                        byte_count_in         = byte_count_ff + 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     if (query_go) begin
                        rd_idx_in = '0;
                        sum_in    = '0;
                        qidx_in   = req_item.instr_index;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STATUS_RANGE;
                     end
                  end
                  MODE_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     cur_line_in   = '0;
                     run_open_in   = 1'b0;
                     cur_len_in    = '0;
                     run_count_in  = '0;
                     last_slot_in  = '0;
                  end
                  MODE_EMPTY: begin
                     rsp_strobe_in = 1'b1;
                     cur_line_in   = '0;
                     run_open_in   = 1'b0;
                     cur_len_in    = '0;
                     run_count_in  = '0;
                     last_slot_in  = '0;
                     byte_count_in = '0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // issue one read per cycle, check the entry that returns
            if (walk_issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               sum_in = sum_next;
            end
            if (walk_hit) begin
               pend_in           = 1'b0;
               rsp_strobe_in     = 1'b1;
               rsp_in.found_line = 16'(run_rdata.line);
            end else if (walk_done) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = STATUS_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         byte_count_ff <= '0;
         run_count_ff  <= '0;
         last_slot_ff  <= '0;
         cur_line_ff   <= '0;
         run_open_ff   <= 1'b0;
         cur_len_ff    <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         run_count_ff  <= run_count_in;
         last_slot_ff  <= last_slot_in;
         cur_line_ff   <= cur_line_in;
         run_open_ff   <= run_open_in;
         cur_len_ff    <= cur_len_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      sum_ff    <= sum_in;
      qidx_ff   <= qidx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_runs_within_bytes: assert property (@(posedge clock) disable iff (reset)
      run_count_ff <= byte_count_ff)
      else $error("run count exceeds byte count");

   a_range_fast: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.mode == MODE_QUERY
       && {1'b0, req_item.instr_index} >= byte_count_ff)
      |=> (rsp_strobe && rsp_item.status == STATUS_RANGE && rsp_item.found_line == '0))
      else $error("out-of-range query not answered next cycle");

   a_append_position: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.mode == MODE_APPEND
       && byte_count_ff != COUNT_BITS'(CODE_DEPTH))
      |=> (rsp_strobe && rsp_item.status == STATUS_OK
           && rsp_item.write_position == $past(byte_count_ff[ADDR_BITS-1:0])))
      else $error("append answered with wrong position");

endmodule
`default_nettype wire
